// ----- src/latency_window_statistics_core_assert.svh -----
// Assertion macros shared by the latency window statistics RTL.
`ifndef LATENCY_WINDOW_STATISTICS_CORE_ASSERT_SVH
`define LATENCY_WINDOW_STATISTICS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LWS_ASSERT_IMP(name, ck, rstn, pre, con) \
	name: assert property (@(posedge ck) disable iff (!(rstn)) (pre) |-> (con)) \
		else $error("assertion failed: same-cycle implication");
`define LWS_ASSERT_NEXT(name, ck, rstn, pre, con) \
	name: assert property (@(posedge ck) disable iff (!(rstn)) (pre) |=> (con)) \
		else $error("assertion failed: next-cycle implication");
`else
`define LWS_ASSERT_IMP(name, ck, rstn, pre, con)
`define LWS_ASSERT_NEXT(name, ck, rstn, pre, con)
`endif
`endif

// ----- src/lwstat_pkg.sv -----
// Types and constants of the latency window statistics block.
`default_nettype none
package lwstat_pkg;
	localparam int CNT_W = 32;
	localparam int SUM_W = 64;
	localparam int PC_W  = 31;
	localparam int PT_W  = 40;
	localparam int RB_W  = 31;
	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 2;
	localparam int RTYPE_W = 2;
	localparam int STEP_W = 6;
	localparam int MILLION_W = 20;

	localparam logic [MILLION_W-1:0] MILLION   = 20'd1000000;
	localparam logic [PT_W-1:0]      GAP_RESET = 40'd1000000;
	localparam logic [RB_W-1:0]      RB_RESET  = 31'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TIME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_BYTES    = 2'd3;

	localparam logic [RTYPE_W-1:0] REQ_START  = 2'd0;
	localparam logic [RTYPE_W-1:0] REQ_SAMPLE = 2'd1;
	localparam logic [RTYPE_W-1:0] REQ_FINISH = 2'd2;

	localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd63;
	localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd31;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_SAMPLE, ST_CHECK, ST_FOLD, ST_AVG, ST_MSQ,
		ST_DEV, ST_RATE, ST_MUL_LO, ST_MUL_HI, ST_EMIT
	} state_t;

	typedef enum logic {OP_DIV, OP_SQRT} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;
endpackage
`default_nettype wire

// ----- src/lwstat_in_if.sv -----
// Input channel: request events.
`default_nettype none
interface lwstat_in_if #(parameter int LATENCY_BITS = 24, parameter int TIME_BITS = 48);
	logic                          valid;
	logic                          ready;
	logic [lwstat_pkg::RTYPE_W-1:0] req_type;
	logic [LATENCY_BITS-1:0]       latency_us;
	logic [TIME_BITS-1:0]          timestamp_us;
	modport source (output valid, req_type, latency_us, timestamp_us, input ready);
	modport sink (input valid, req_type, latency_us, timestamp_us, output ready);
endinterface
`default_nettype wire

// ----- src/lwstat_out_if.sv -----
// Output channel: window and run reports.
`default_nettype none
interface lwstat_out_if #(parameter int LATENCY_BITS = 24, parameter int TIME_BITS = 48);
	logic                        valid;
	logic                        ready;
	logic                        is_total;
	logic                        last;
	logic [lwstat_pkg::CNT_W-1:0] req_count;
	logic [lwstat_pkg::SUM_W-1:0] latency_sum;
	logic [LATENCY_BITS-1:0]     latency_min;
	logic [LATENCY_BITS-1:0]     latency_max;
	logic [LATENCY_BITS-1:0]     latency_avg;
	logic [LATENCY_BITS-1:0]     latency_dev;
	logic [lwstat_pkg::CNT_W-1:0] ops_per_sec;
	logic [lwstat_pkg::SUM_W-1:0] bytes_per_sec;
	logic [TIME_BITS-1:0]        elapsed_us;
	modport source (output valid, is_total, last, req_count, latency_sum, latency_min,
		latency_max, latency_avg, latency_dev, ops_per_sec, bytes_per_sec, elapsed_us,
		input ready);
	modport sink (input valid, is_total, last, req_count, latency_sum, latency_min,
		latency_max, latency_avg, latency_dev, ops_per_sec, bytes_per_sec, elapsed_us,
		output ready);
endinterface
`default_nettype wire

// ----- src/lwstat_cfg_if.sv -----
// Configuration write channel.
`default_nettype none
interface lwstat_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lwstat_pkg::CFG_IDX_W-1:0] index;
	logic [lwstat_pkg::CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/lwstat_unit.sv -----
// Shared bit-serial unit: 64-bit restoring divider and integer square root.
`default_nettype none
module lwstat_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lwstat_pkg::unit_req_t       req,
	input  wire logic [lwstat_pkg::SUM_W-1:0] opa,
	input  wire logic [lwstat_pkg::SUM_W-1:0] opb,
	output lwstat_pkg::unit_rsp_t            rsp,
	output logic [lwstat_pkg::SUM_W-1:0]     result
);
	localparam int W = lwstat_pkg::SUM_W;

	// div: ra = quotient/dividend, rb = divisor, rc = remainder
	// sqrt: ra = bit, rb = root, rc = radicand
	logic [W-1:0]    ra_q, rb_q;
	logic [W:0]      rc_q;
	logic [lwstat_pkg::STEP_W-1:0] cnt_q;
	lwstat_pkg::unit_op_t op_q;
	logic            busy_q, done_q;

	logic [W:0]   minu;
	logic [W:0]   subt;
	logic [W+1:0] diff;
	logic         ge;

	always_comb begin
		if (op_q == lwstat_pkg::OP_DIV) begin
			minu = {rc_q[W-1:0], ra_q[W-1]};
			subt = {1'b0, rb_q};
		end else begin
			minu = rc_q;
			subt = {1'b0, rb_q + ra_q};
		end
		diff = {1'b0, minu} - {1'b0, subt};
		ge   = !diff[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= lwstat_pkg::OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == lwstat_pkg::OP_DIV) ? lwstat_pkg::DIV_STEPS
					: lwstat_pkg::SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == lwstat_pkg::OP_DIV) begin
				ra_q <= opa;
				rb_q <= opb;
				rc_q <= '0;
			end else begin
				ra_q <= {2'b01, {(W-2){1'b0}}};
				rb_q <= '0;
				rc_q <= {1'b0, opa};
			end
		end else if (busy_q) begin
			if (op_q == lwstat_pkg::OP_DIV) begin
				ra_q <= {ra_q[W-2:0], ge};
				rc_q <= ge ? diff[W:0] : minu;
			end else begin
				if (ge) begin
					rc_q <= diff[W:0];
					rb_q <= (rb_q >> 1) + ra_q;
				end else begin
					rb_q <= rb_q >> 1;
				end
				ra_q <= ra_q >> 2;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = (op_q == lwstat_pkg::OP_DIV) ? ra_q : rb_q;
endmodule
`default_nettype wire

// ----- src/latency_window_statistics_core.sv -----
// Top level of the request-latency window statistics monitor.
// A start word is applied in ST_START, a sample in ST_SAMPLE then ST_CHECK; a reporting word
//   runs ST_FOLD, the unit states, then ST_MUL_LO, ST_MUL_HI and ST_EMIT: up to three 64-step
//   divisions and one 32-step square root on one shared unit.
// One word at a time; input ready only while idle, so after a reporting word the next is taken
//   only once its report is loaded into the output register, later while the output stalls.
// Reset (arst_n low, asynchronous): statistics cleared, min fields all ones, configuration
//   to its defaults (gap 1000000 us, 4096 bytes), no report pending.
`default_nettype none
`include "latency_window_statistics_core_assert.svh"
module latency_window_statistics_core #(
	parameter int LATENCY_BITS = 24,
	parameter int TIME_BITS    = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	lwstat_in_if.sink    in_ch,
	lwstat_out_if.source out_ch,
	lwstat_cfg_if.sink   cfg_ch
);
	localparam int LB    = LATENCY_BITS;
	localparam int TB    = TIME_BITS;
	localparam int CW    = lwstat_pkg::CNT_W;
	localparam int SW    = lwstat_pkg::SUM_W;
	localparam int TA_W  = (TB > lwstat_pkg::PT_W ? TB : lwstat_pkg::PT_W) + 1;
	localparam int PW    = SW - 1;
	localparam logic [LB-1:0] LAT_MAX  = {LB{1'b1}};
	localparam logic [TB-1:0] TS_CEIL  = {TB{1'b1}};

	// Saturating time add: clamp at the largest time value.
	function automatic logic [TB-1:0] time_add(input logic [TB-1:0] t,
		input logic [lwstat_pkg::PT_W-1:0] d);
		logic [TA_W-1:0] s;
		s = TA_W'(t) + TA_W'(d);
		return (s > TA_W'(TS_CEIL)) ? TS_CEIL : s[TB-1:0];
	endfunction

	function automatic logic [SW-1:0] sat_add64(input logic [SW-1:0] a,
		input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SW] ? {SW{1'b1}} : s[SW-1:0];
	endfunction

	function automatic logic [CW-1:0] sat_add32(input logic [CW-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	// Configuration registers
	logic [lwstat_pkg::PC_W-1:0] pc_q;
	logic [lwstat_pkg::PT_W-1:0] pt_q;
	logic [lwstat_pkg::PT_W-1:0] gap_q;
	logic [lwstat_pkg::RB_W-1:0] rb_q;

	// Captured input word
	logic [lwstat_pkg::RTYPE_W-1:0] it_type_q;
	logic [LB-1:0] it_lat_q;
	logic [TB-1:0] it_ts_q;

	// Window and run statistics
	logic [CW-1:0] win_count_q, run_count_q;
	logic [SW-1:0] win_sum_q, win_sumsq_q, run_sum_q, run_sumsq_q;
	logic [LB-1:0] win_min_q, win_max_q, run_min_q, run_max_q;
	logic [TB-1:0] deadline_q, run_start_q;

	// Report working registers
	logic          rp_total_q;
	logic [CW-1:0] rp_count_q;
	logic [SW-1:0] rp_sum_q, rp_sumsq_q;
	logic [LB-1:0] rp_min_q, rp_max_q;
	logic [TB-1:0] rp_elapsed_q;
	logic [SW-1:0] avg_q, a2_q, rad_q, num_q, rate_q;
	logic [CW-1:0] dev_q;
	logic [PW-1:0] plo_q, phi_q;

	// Products ahead of their registers
	logic [SW-1:0] avg_sq, num_d;
	logic [PW-1:0] plo_d, phi_d;

	// Output register
	logic          out_valid_q;
	logic          o_total_q;
	logic [CW-1:0] o_count_q, o_ops_q;
	logic [SW-1:0] o_sum_q, o_bytes_q;
	logic [LB-1:0] o_min_q, o_max_q, o_avg_q, o_dev_q;
	logic [TB-1:0] o_elapsed_q;

	lwstat_pkg::state_t state_q, state_d;
	logic go_q, go_d;
	lwstat_pkg::unit_req_t unit_req;
	lwstat_pkg::unit_rsp_t unit_rsp;
	logic [SW-1:0] unit_a, unit_b, unit_res;
	logic in_take, load_out, hit;
	logic take_known, unit_state;

	// Fold of the window into the run totals
	logic [CW-1:0] f_count, snap_count;
	logic [SW-1:0] f_sum, f_sumsq, snap_sum;
	logic [LB-1:0] f_min, f_max;
	logic [2*LB-1:0] lat_sq;
	logic [95:0] bsum;

	assign in_take = in_ch.valid && in_ch.ready;
	assign f_count = sat_add32(run_count_q, win_count_q);
	assign f_sum   = sat_add64(run_sum_q, win_sum_q);
	assign f_sumsq = sat_add64(run_sumsq_q, win_sumsq_q);
	assign f_min   = (win_min_q < run_min_q) ? win_min_q : run_min_q;
	assign f_max   = (win_max_q > run_max_q) ? win_max_q : run_max_q;
	assign snap_count = (it_type_q == lwstat_pkg::REQ_FINISH) ? f_count : win_count_q;
	assign snap_sum   = (it_type_q == lwstat_pkg::REQ_FINISH) ? f_sum : win_sum_q;
	assign lat_sq     = it_lat_q * it_lat_q;

	assign avg_sq = avg_q[CW-1:0] * avg_q[CW-1:0];
	assign num_d  = lwstat_pkg::MILLION * rp_count_q;
	assign plo_d  = rate_q[31:0] * rb_q;
	assign phi_d  = rate_q[63:32] * rb_q;

	// Window trigger: count reached, or timestamp plus gap at or past the deadline
	assign hit = (pc_q != '0 && win_count_q >= CW'(pc_q)) ||
		(pt_q != '0 && time_add(it_ts_q, gap_q) >= deadline_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lwstat_pkg::ST_IDLE: begin
				if (in_take) begin
					case (in_ch.req_type)
						lwstat_pkg::REQ_START:  state_d = lwstat_pkg::ST_START;
						lwstat_pkg::REQ_SAMPLE: state_d = lwstat_pkg::ST_SAMPLE;
						lwstat_pkg::REQ_FINISH: state_d = lwstat_pkg::ST_FOLD;
						default:                state_d = lwstat_pkg::ST_IDLE;
					endcase
				end
			end
			lwstat_pkg::ST_START:  state_d = lwstat_pkg::ST_IDLE;
			lwstat_pkg::ST_SAMPLE: state_d = lwstat_pkg::ST_CHECK;
			lwstat_pkg::ST_CHECK:  state_d = hit ? lwstat_pkg::ST_FOLD : lwstat_pkg::ST_IDLE;
			lwstat_pkg::ST_FOLD: begin
				if (snap_count != '0)
					state_d = lwstat_pkg::ST_AVG;
				else if (snap_sum != '0)
					state_d = lwstat_pkg::ST_RATE;
				else
					state_d = lwstat_pkg::ST_MUL_LO;
			end
			lwstat_pkg::ST_AVG: begin
				if (unit_rsp.done)
					state_d = lwstat_pkg::ST_MSQ;
			end
			lwstat_pkg::ST_MSQ: begin
				if (unit_rsp.done) begin
					if (unit_res > a2_q)
						state_d = lwstat_pkg::ST_DEV;
					else if (rp_sum_q != '0)
						state_d = lwstat_pkg::ST_RATE;
					else
						state_d = lwstat_pkg::ST_MUL_LO;
				end
			end
			lwstat_pkg::ST_DEV: begin
				if (unit_rsp.done)
					state_d = (rp_sum_q != '0) ? lwstat_pkg::ST_RATE : lwstat_pkg::ST_MUL_LO;
			end
			lwstat_pkg::ST_RATE: begin
				if (unit_rsp.done)
					state_d = lwstat_pkg::ST_MUL_LO;
			end
			lwstat_pkg::ST_MUL_LO: state_d = lwstat_pkg::ST_MUL_HI;
			lwstat_pkg::ST_MUL_HI: state_d = lwstat_pkg::ST_EMIT;
			lwstat_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ch.ready)
					state_d = lwstat_pkg::ST_IDLE;
			end
			default: state_d = lwstat_pkg::ST_IDLE;
		endcase
	end

	// Launch the shared unit on entry to a unit state
	assign go_d = (state_d != state_q) && (state_d == lwstat_pkg::ST_AVG ||
		state_d == lwstat_pkg::ST_MSQ || state_d == lwstat_pkg::ST_DEV ||
		state_d == lwstat_pkg::ST_RATE);

	// State outputs
	always_comb begin
		in_ch.ready    = 1'b0;
		load_out       = 1'b0;
		unit_req.start = go_q;
		unit_req.op    = lwstat_pkg::OP_DIV;
		unit_a         = rp_sum_q;
		unit_b         = SW'(rp_count_q);
		case (state_q)
			lwstat_pkg::ST_IDLE: in_ch.ready = 1'b1;
			lwstat_pkg::ST_MSQ:  unit_a = rp_sumsq_q;
			lwstat_pkg::ST_DEV: begin
				unit_req.op = lwstat_pkg::OP_SQRT;
				unit_a      = rad_q;
			end
			lwstat_pkg::ST_RATE: begin
				unit_a = num_q;
				unit_b = rp_sum_q;
			end
			lwstat_pkg::ST_EMIT: load_out = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	lwstat_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.opa    (unit_a),
		.opb    (unit_b),
		.rsp    (unit_rsp),
		.result (unit_res)
	);

	// Control state, configuration and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lwstat_pkg::ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			pt_q        <= '0;
			gap_q       <= lwstat_pkg::GAP_RESET;
			rb_q        <= lwstat_pkg::RB_RESET;
			win_count_q <= '0;
			win_sum_q   <= '0;
			win_sumsq_q <= '0;
			win_min_q   <= LAT_MAX;
			win_max_q   <= '0;
			run_count_q <= '0;
			run_sum_q   <= '0;
			run_sumsq_q <= '0;
			run_min_q   <= LAT_MAX;
			run_max_q   <= '0;
			deadline_q  <= '0;
			run_start_q <= '0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;

			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					lwstat_pkg::CFG_PERIOD_COUNT: pc_q  <= cfg_ch.data[lwstat_pkg::PC_W-1:0];
					lwstat_pkg::CFG_PERIOD_TIME:  pt_q  <= cfg_ch.data[lwstat_pkg::PT_W-1:0];
					lwstat_pkg::CFG_GAP:          gap_q <= cfg_ch.data[lwstat_pkg::PT_W-1:0];
					lwstat_pkg::CFG_REQ_BYTES:    rb_q  <= cfg_ch.data[lwstat_pkg::RB_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				lwstat_pkg::ST_START: begin
					// clear everything and arm the first deadline
					win_count_q <= '0;
					win_sum_q   <= '0;
					win_sumsq_q <= '0;
					win_min_q   <= LAT_MAX;
					win_max_q   <= '0;
					run_count_q <= '0;
					run_sum_q   <= '0;
					run_sumsq_q <= '0;
					run_min_q   <= LAT_MAX;
					run_max_q   <= '0;
					run_start_q <= it_ts_q;
					deadline_q  <= time_add(it_ts_q, pt_q);
				end
				lwstat_pkg::ST_SAMPLE: begin
					win_count_q <= sat_add32(win_count_q, CW'(1));
					win_sum_q   <= sat_add64(win_sum_q, SW'(it_lat_q));
					win_sumsq_q <= sat_add64(win_sumsq_q, SW'(lat_sq));
					if (it_lat_q < win_min_q)
						win_min_q <= it_lat_q;
					if (it_lat_q > win_max_q)
						win_max_q <= it_lat_q;
				end
				lwstat_pkg::ST_FOLD: begin
					// fold the window into the run and clear it
					run_count_q <= f_count;
					run_sum_q   <= f_sum;
					run_sumsq_q <= f_sumsq;
					run_min_q   <= f_min;
					run_max_q   <= f_max;
					win_count_q <= '0;
					win_sum_q   <= '0;
					win_sumsq_q <= '0;
					win_min_q   <= LAT_MAX;
					win_max_q   <= '0;
					if (it_type_q != lwstat_pkg::REQ_FINISH)
						deadline_q <= time_add(it_ts_q, pt_q);
				end
				default: ;
			endcase
		end
	end

	// Payload and report datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			it_type_q <= in_ch.req_type;
			it_lat_q  <= in_ch.latency_us;
			it_ts_q   <= in_ch.timestamp_us;
		end

		// products registered ahead of use
		a2_q  <= (avg_q > SW'({CW{1'b1}})) ? {SW{1'b1}} : avg_sq;
		num_q <= num_d;

		case (state_q)
			lwstat_pkg::ST_FOLD: begin
				// snapshot: window figures, or folded totals on finish
				if (it_type_q == lwstat_pkg::REQ_FINISH) begin
					rp_total_q   <= 1'b1;
					rp_count_q   <= f_count;
					rp_sum_q     <= f_sum;
					rp_sumsq_q   <= f_sumsq;
					rp_min_q     <= f_min;
					rp_max_q     <= f_max;
					rp_elapsed_q <= (it_ts_q >= run_start_q) ? it_ts_q - run_start_q : '0;
				end else begin
					rp_total_q   <= 1'b0;
					rp_count_q   <= win_count_q;
					rp_sum_q     <= win_sum_q;
					rp_sumsq_q   <= win_sumsq_q;
					rp_min_q     <= win_min_q;
					rp_max_q     <= win_max_q;
					rp_elapsed_q <= '0;
				end
				avg_q  <= '0;
				dev_q  <= '0;
				rate_q <= '0;
			end
			lwstat_pkg::ST_AVG: begin
				if (unit_rsp.done)
					avg_q <= unit_res;
			end
			lwstat_pkg::ST_MSQ: begin
				if (unit_rsp.done)
					rad_q <= unit_res - a2_q;
			end
			lwstat_pkg::ST_DEV: begin
				if (unit_rsp.done)
					dev_q <= unit_res[CW-1:0];
			end
			lwstat_pkg::ST_RATE: begin
				if (unit_rsp.done)
					rate_q <= unit_res;
			end
			lwstat_pkg::ST_MUL_LO: plo_q <= plo_d;
			lwstat_pkg::ST_MUL_HI: phi_q <= phi_d;
			default: ;
		endcase

		if (load_out) begin
			o_total_q   <= rp_total_q;
			o_count_q   <= rp_count_q;
			o_sum_q     <= rp_sum_q;
			o_min_q     <= rp_min_q;
			o_max_q     <= rp_max_q;
			o_avg_q     <= (avg_q > SW'(LAT_MAX)) ? LAT_MAX : avg_q[LB-1:0];
			o_dev_q     <= (dev_q > CW'(LAT_MAX)) ? LAT_MAX : dev_q[LB-1:0];
			o_ops_q     <= (rate_q[SW-1:CW] != '0) ? {CW{1'b1}} : rate_q[CW-1:0];
			o_bytes_q   <= (bsum[95:64] != '0) ? {SW{1'b1}} : bsum[63:0];
			o_elapsed_q <= rp_elapsed_q;
		end
	end

	// Recombine the two partial products of rate times request bytes
	assign bsum = {1'b0, phi_q, 32'b0} + 96'(plo_q);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.is_total      = o_total_q;
	assign out_ch.last          = 1'b1;
	assign out_ch.req_count     = o_count_q;
	assign out_ch.latency_sum   = o_sum_q;
	assign out_ch.latency_min   = o_min_q;
	assign out_ch.latency_max   = o_max_q;
	assign out_ch.latency_avg   = o_avg_q;
	assign out_ch.latency_dev   = o_dev_q;
	assign out_ch.ops_per_sec   = o_ops_q;
	assign out_ch.bytes_per_sec = o_bytes_q;
	assign out_ch.elapsed_us    = o_elapsed_q;
	assign cfg_ch.ready         = 1'b1;

	// an unknown request type is dropped and leaves the input ready
	assign take_known = in_take && (in_ch.req_type == lwstat_pkg::REQ_START ||
		in_ch.req_type == lwstat_pkg::REQ_SAMPLE || in_ch.req_type == lwstat_pkg::REQ_FINISH);
	assign unit_state = state_q == lwstat_pkg::ST_AVG || state_q == lwstat_pkg::ST_MSQ ||
		state_q == lwstat_pkg::ST_DEV || state_q == lwstat_pkg::ST_RATE;

	`LWS_ASSERT_IMP(a_done_in_unit_state, clk, arst_n, unit_rsp.done, unit_state)
	`LWS_ASSERT_NEXT(a_one_word_at_a_time, clk, arst_n, take_known, !in_ch.ready)
	`LWS_ASSERT_IMP(a_min_below_max, clk, arst_n, win_count_q != '0, win_min_q <= win_max_q)
endmodule
`default_nettype wire
